### src/ifscg_pkg.sv
// Shared types and constants of the chaos-game point generator.
package ifscg_pkg;

  // Configuration port
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_THR_FIRST,
    REG_THR_SECOND,
    REG_THR_THIRD,
    REG_X_SCALE,
    REG_Y_SCALE,
    REG_X_OFFSET,
    REG_Y_OFFSET
  } reg_idx_t;

  typedef struct packed {
    logic        [14:0] thr_first;
    logic        [14:0] thr_second;
    logic        [14:0] thr_third;
    logic        [7:0]  x_scale;
    logic        [7:0]  y_scale;
    logic signed [9:0]  x_offset;
    logic signed [9:0]  y_offset;
  } cfg_t;

  // Map coefficients in hundredths, indexed by map
  localparam int COEF_A_H [4] = '{0, 20, -15, 85};
  localparam int COEF_B_H [4] = '{0, -25, 30, 5};
  localparam int COEF_C_H [4] = '{0, 20, 25, -50};
  localparam int COEF_D_H [4] = '{15, 20, 25, 85};
  localparam int COEF_F_H [4] = '{0, 150, 45, 150};

  // Microprogram
  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE  = 4'd0;
  localparam step_t STEP_FIRST = 4'd1;
  localparam step_t STEP_LAST  = 4'd10;

  typedef enum logic [1:0] {OPA_X, OPA_Y, OPA_NX} opa_sel_t;
  typedef enum logic [2:0] {OPB_A, OPB_B, OPB_C, OPB_D, OPB_SX, OPB_SY} opb_sel_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_LOAD_F} acc_op_t;
  typedef enum logic [1:0] {SEQ_NEXT, SEQ_WAIT_IN, SEQ_WAIT_OUT, SEQ_JUMP} seq_t;

  typedef struct packed {
    logic     in_ready;
    opa_sel_t opa;
    opb_sel_t opb;
    acc_op_t  acc_op;
    logic     nx_load;
    logic     pt_load;
    logic     psum_load;
    logic     psum_y;
    logic     px_load;
    logic     py_load;
    logic     out_load;
    seq_t     seq;
    step_t    target;
  } cw_t;

  typedef struct packed {
    logic in_fire;
    logic out_free;
  } stat_t;

endpackage

### src/ifscg_if.sv
// Request channels: random draws in, plotted points out.
interface ifscg_draw_if;
  logic        valid;
  logic        ready;
  logic [14:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink (input valid, input random_value, output ready);
endinterface

interface ifscg_plot_if;
  logic       valid;
  logic       ready;
  logic [9:0] column;
  logic [8:0] row;
  logic       on_screen;
  logic [1:0] map_index;

  modport source (output valid, output column, output row, output on_screen,
                  output map_index, input ready);
  modport sink (input valid, input column, input row, input on_screen,
                input map_index, output ready);
endinterface

### src/ifscg_cfg.sv
// APB register file for thresholds, scales and offsets.
module ifscg_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ifscg_pkg::PADDR_W-1:0] paddr,
  input  logic [ifscg_pkg::PDATA_W-1:0] pwdata,
  output logic [ifscg_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  output ifscg_pkg::cfg_t               cfg
);

  ifscg_pkg::reg_idx_t idx;
  logic                wr;

  assign idx    = ifscg_pkg::reg_idx_t'(paddr[ifscg_pkg::PADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr_first  <= 15'd320;
      cfg.thr_second <= 15'd2600;
      cfg.thr_third  <= 15'd4900;
      cfg.x_scale    <= 8'd25;
      cfg.y_scale    <= 8'd25;
      cfg.x_offset   <= 10'sd0;
      cfg.y_offset   <= -10'sd160;
    end else if (wr) begin
      case (idx)
        ifscg_pkg::REG_THR_FIRST:  cfg.thr_first  <= pwdata[14:0];
        ifscg_pkg::REG_THR_SECOND: cfg.thr_second <= pwdata[14:0];
        ifscg_pkg::REG_THR_THIRD:  cfg.thr_third  <= pwdata[14:0];
        ifscg_pkg::REG_X_SCALE:    cfg.x_scale    <= pwdata[7:0];
        ifscg_pkg::REG_Y_SCALE:    cfg.y_scale    <= pwdata[7:0];
        ifscg_pkg::REG_X_OFFSET:   cfg.x_offset   <= $signed(pwdata[9:0]);
        ifscg_pkg::REG_Y_OFFSET:   cfg.y_offset   <= $signed(pwdata[9:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ifscg_pkg::REG_THR_FIRST:  prdata = {17'd0, cfg.thr_first};
      ifscg_pkg::REG_THR_SECOND: prdata = {17'd0, cfg.thr_second};
      ifscg_pkg::REG_THR_THIRD:  prdata = {17'd0, cfg.thr_third};
      ifscg_pkg::REG_X_SCALE:    prdata = {24'd0, cfg.x_scale};
      ifscg_pkg::REG_Y_SCALE:    prdata = {24'd0, cfg.y_scale};
      ifscg_pkg::REG_X_OFFSET:   prdata = {22'd0, cfg.x_offset};
      ifscg_pkg::REG_Y_OFFSET:   prdata = {22'd0, cfg.y_offset};
      default:                   prdata = '0;
    endcase
  end

endmodule

### src/ifscg_ucode.sv
// Microcode sequencer: step counter, control ROM and jump logic.
module ifscg_ucode (
  input  logic             clk,
  input  logic             rst,
  input  ifscg_pkg::stat_t stat,
  output ifscg_pkg::cw_t   cw
);

  ifscg_pkg::step_t step;
  ifscg_pkg::step_t step_next;
  ifscg_pkg::cw_t   word;

  function automatic ifscg_pkg::cw_t rom(input ifscg_pkg::step_t s);
    ifscg_pkg::cw_t w;
    w        = '0;
    w.seq    = ifscg_pkg::SEQ_NEXT;
    w.opa    = ifscg_pkg::OPA_X;
    w.opb    = ifscg_pkg::OPB_A;
    w.acc_op = ifscg_pkg::ACC_HOLD;
    w.target = ifscg_pkg::STEP_IDLE;
    case (s)
      4'd0: begin                       // wait for a draw, latch map
        w.in_ready = 1'b1;
        w.seq      = ifscg_pkg::SEQ_WAIT_IN;
      end
      4'd1: begin                       // a*x
        w.opa = ifscg_pkg::OPA_X;
        w.opb = ifscg_pkg::OPB_A;
      end
      4'd2: begin                       // b*y
        w.opa    = ifscg_pkg::OPA_Y;
        w.opb    = ifscg_pkg::OPB_B;
        w.acc_op = ifscg_pkg::ACC_LOAD;
      end
      4'd3: begin                       // c*x
        w.opa    = ifscg_pkg::OPA_X;
        w.opb    = ifscg_pkg::OPB_C;
        w.acc_op = ifscg_pkg::ACC_ADD;
      end
      4'd4: begin                       // d*y, new x out of acc
        w.opa     = ifscg_pkg::OPA_Y;
        w.opb     = ifscg_pkg::OPB_D;
        w.acc_op  = ifscg_pkg::ACC_LOAD_F;
        w.nx_load = 1'b1;
      end
      4'd5: w.acc_op = ifscg_pkg::ACC_ADD;
      4'd6: begin                       // commit point, x*x_scale
        w.opa     = ifscg_pkg::OPA_NX;
        w.opb     = ifscg_pkg::OPB_SX;
        w.pt_load = 1'b1;
      end
      4'd7: begin                       // y*y_scale, x offset sum
        w.opa       = ifscg_pkg::OPA_Y;
        w.opb       = ifscg_pkg::OPB_SY;
        w.psum_load = 1'b1;
      end
      4'd8: begin
        w.px_load   = 1'b1;
        w.psum_load = 1'b1;
        w.psum_y    = 1'b1;
      end
      4'd9: w.py_load = 1'b1;
      4'd10: begin                      // clip and hand over
        w.out_load = 1'b1;
        w.seq      = ifscg_pkg::SEQ_WAIT_OUT;
      end
      default: w.seq = ifscg_pkg::SEQ_JUMP;
    endcase
    return w;
  endfunction

  assign word = rom(step);

  always_comb begin
    cw = word;
    if (word.seq == ifscg_pkg::SEQ_WAIT_OUT && !stat.out_free) begin
      cw.out_load = 1'b0;
    end
  end

  always_comb begin
    case (word.seq)
      ifscg_pkg::SEQ_NEXT:     step_next = step + 1'b1;
      ifscg_pkg::SEQ_WAIT_IN:  step_next = stat.in_fire ? step + 1'b1 : step;
      ifscg_pkg::SEQ_WAIT_OUT: step_next = stat.out_free ? word.target : step;
      ifscg_pkg::SEQ_JUMP:     step_next = word.target;
      default:                 step_next = ifscg_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ifscg_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  a_fire_starts: assert property (@(posedge clk) disable iff (rst)
    stat.in_fire |=> step == ifscg_pkg::STEP_FIRST)
    else $error("accepted draw did not start the program");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= ifscg_pkg::STEP_LAST)
    else $error("step counter left the program");

endmodule

### src/ifscg_datapath.sv
// Datapath: shared multiplier, accumulator, point, pixel and output registers.
module ifscg_datapath #(
  parameter int SCREEN_HALF_WIDTH  = 320,
  parameter int SCREEN_HALF_HEIGHT = 240,
  parameter int FRACTION_BITS      = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  ifscg_pkg::cw_t   cw,
  input  ifscg_pkg::cfg_t  cfg,
  input  logic             in_fire,
  input  logic [14:0]      random_value,
  input  logic             out_ready,
  output logic             out_free,
  output logic             out_valid,
  output logic [9:0]       column,
  output logic [8:0]       row,
  output logic             on_screen,
  output logic [1:0]       map_index
);

  localparam int COEF_W = FRACTION_BITS + 2;
  localparam int PROD_W = 32 + COEF_W;
  localparam int ACC_W  = PROD_W;
  localparam int RND_W  = ACC_W - FRACTION_BITS;
  localparam int SUM_W  = PROD_W + 1;
  localparam int PXW    = SUM_W - FRACTION_BITS;

  function automatic logic signed [COEF_W-1:0] to_fixed(input int n);
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] s;
    mag = (n < 0) ? 64'(-n) : 64'(n);
    q   = ((mag << FRACTION_BITS) + 64'd50) / 64'd100;
    s   = (n < 0) ? -q : q;
    return s[COEF_W-1:0];
  endfunction

  localparam logic signed [COEF_W-1:0] COEF_A [4] = '{
    to_fixed(ifscg_pkg::COEF_A_H[0]), to_fixed(ifscg_pkg::COEF_A_H[1]),
    to_fixed(ifscg_pkg::COEF_A_H[2]), to_fixed(ifscg_pkg::COEF_A_H[3])};
  localparam logic signed [COEF_W-1:0] COEF_B [4] = '{
    to_fixed(ifscg_pkg::COEF_B_H[0]), to_fixed(ifscg_pkg::COEF_B_H[1]),
    to_fixed(ifscg_pkg::COEF_B_H[2]), to_fixed(ifscg_pkg::COEF_B_H[3])};
  localparam logic signed [COEF_W-1:0] COEF_C [4] = '{
    to_fixed(ifscg_pkg::COEF_C_H[0]), to_fixed(ifscg_pkg::COEF_C_H[1]),
    to_fixed(ifscg_pkg::COEF_C_H[2]), to_fixed(ifscg_pkg::COEF_C_H[3])};
  localparam logic signed [COEF_W-1:0] COEF_D [4] = '{
    to_fixed(ifscg_pkg::COEF_D_H[0]), to_fixed(ifscg_pkg::COEF_D_H[1]),
    to_fixed(ifscg_pkg::COEF_D_H[2]), to_fixed(ifscg_pkg::COEF_D_H[3])};
  // f enters at product scale, so it is shifted up once more
  localparam logic signed [ACC_W-1:0] F_TERM [4] = '{
    ACC_W'(to_fixed(ifscg_pkg::COEF_F_H[0])) <<< FRACTION_BITS,
    ACC_W'(to_fixed(ifscg_pkg::COEF_F_H[1])) <<< FRACTION_BITS,
    ACC_W'(to_fixed(ifscg_pkg::COEF_F_H[2])) <<< FRACTION_BITS,
    ACC_W'(to_fixed(ifscg_pkg::COEF_F_H[3])) <<< FRACTION_BITS};

  localparam logic signed [PXW-1:0]   HW_S  = PXW'(SCREEN_HALF_WIDTH);
  localparam logic signed [PXW-1:0]   HH_S  = PXW'(SCREEN_HALF_HEIGHT);
  localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) <<< (FRACTION_BITS - 1);

  // round to nearest, ties up, then clamp to 32 bits
  function automatic logic signed [31:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] t;
    logic signed [RND_W-1:0] r;
    t = a + HALF;
    r = $signed(t[ACC_W-1:FRACTION_BITS]);
    if ((&r[RND_W-1:31]) || !(|r[RND_W-1:31])) begin
      return r[31:0];
    end
    return r[RND_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  // shift right with rounding toward zero
  function automatic logic signed [PXW-1:0] trunc_px(input logic signed [SUM_W-1:0] v);
    logic corr;
    corr = v[SUM_W-1] && (|v[FRACTION_BITS-1:0]);
    return $signed(v[SUM_W-1:FRACTION_BITS]) + $signed({{(PXW-1){1'b0}}, corr});
  endfunction

  logic signed [31:0]       x;
  logic signed [31:0]       y;
  logic signed [31:0]       nx;
  logic [1:0]               map;
  logic [1:0]               map_sel;
  logic signed [31:0]       opa;
  logic signed [COEF_W-1:0] opb;
  logic signed [PROD_W-1:0] mul;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SUM_W-1:0]  psum;
  logic signed [PXW-1:0]    px;
  logic signed [PXW-1:0]    py;
  logic signed [PXW-1:0]    col_sum;
  logic signed [PXW-1:0]    row_sum;
  logic signed [9:0]        offset;
  logic                     vis;

  // cascaded threshold compare, in register order
  always_comb begin
    if (random_value < cfg.thr_first) begin
      map_sel = 2'd0;
    end else if (random_value < cfg.thr_second) begin
      map_sel = 2'd1;
    end else if (random_value < cfg.thr_third) begin
      map_sel = 2'd2;
    end else begin
      map_sel = 2'd3;
    end
  end

  always_comb begin
    case (cw.opa)
      ifscg_pkg::OPA_X:  opa = x;
      ifscg_pkg::OPA_Y:  opa = y;
      ifscg_pkg::OPA_NX: opa = nx;
      default:           opa = x;
    endcase
  end

  always_comb begin
    case (cw.opb)
      ifscg_pkg::OPB_A:  opb = COEF_A[map];
      ifscg_pkg::OPB_B:  opb = COEF_B[map];
      ifscg_pkg::OPB_C:  opb = COEF_C[map];
      ifscg_pkg::OPB_D:  opb = COEF_D[map];
      ifscg_pkg::OPB_SX: opb = $signed({{(COEF_W-8){1'b0}}, cfg.x_scale});
      ifscg_pkg::OPB_SY: opb = $signed({{(COEF_W-8){1'b0}}, cfg.y_scale});
      default:           opb = '0;
    endcase
  end

  assign mul     = PROD_W'(opa) * PROD_W'(opb);
  assign offset  = cw.psum_y ? cfg.y_offset : cfg.x_offset;
  assign vis     = (px >= -HW_S) && (px < HW_S) && (py >= -HH_S) && (py < HH_S);
  assign col_sum = px + HW_S;
  assign row_sum = py + HH_S;
  assign out_free = !out_valid || out_ready;

  // payload registers
  always_ff @(posedge clk) begin
    prod <= mul;
    if (in_fire) begin
      map <= map_sel;
    end
    case (cw.acc_op)
      ifscg_pkg::ACC_LOAD:   acc <= prod;
      ifscg_pkg::ACC_ADD:    acc <= acc + prod;
      ifscg_pkg::ACC_LOAD_F: acc <= prod + F_TERM[map];
      default:               acc <= acc;
    endcase
    if (cw.nx_load) begin
      nx <= round_sat(acc);
    end
    if (cw.psum_load) begin
      psum <= SUM_W'(prod) + (SUM_W'(offset) <<< FRACTION_BITS);
    end
    if (cw.px_load) begin
      px <= trunc_px(psum);
    end
    if (cw.py_load) begin
      py <= trunc_px(psum);
    end
    if (cw.out_load) begin
      column    <= vis ? col_sum[9:0] : 10'd0;
      row       <= vis ? row_sum[8:0] : 9'd0;
      on_screen <= vis;
      map_index <= map;
    end
  end

  // point state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      x         <= '0;
      y         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cw.pt_load) begin
        x <= nx;
        y <= round_sat(acc);
      end
      if (cw.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cw.out_load |-> out_free)
    else $error("output register overwritten before it was taken");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cw.out_load |=> out_valid)
    else $error("result loaded but not presented");

  a_off_screen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !on_screen) |-> (column == 10'd0 && row == 9'd0))
    else $error("off-screen result with nonzero coordinates");

endmodule

### src/ifs_chaos_game_point_generator.sv
// Top level of the chaos-game point generator.
//
// Each request on the draw channel carries one 15-bit random value; three
// threshold registers, compared in cascade, pick one of four fixed affine
// maps, which is applied to the internal point (signed fixed point with
// FRACTION_BITS fraction bits, origin after reset). The new point is scaled,
// offset, truncated toward zero and clipped to a window of
// 2*SCREEN_HALF_WIDTH by 2*SCREEN_HALF_HEIGHT pixels; one request leaves on
// the plot channel with column, row, on-screen flag and map index. The work
// runs as an eleven-step microprogram over one shared multiplier (six
// products per point: four for the map, two for the scaling), so a draw
// is accepted in the idle step, its result is loaded into the output
// register at the last step, and the next draw can be taken in the cycle
// after that, so a new draw waits until the last one is through. The output
// register holds a finished result while the next point is computed; the
// program only waits at its last step when that register is still full.
// Registers sit on an APB port at byte address 4*index.
module ifs_chaos_game_point_generator #(
  parameter int SCREEN_HALF_WIDTH  = 320,
  parameter int SCREEN_HALF_HEIGHT = 240,
  parameter int FRACTION_BITS      = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  ifscg_draw_if.sink                    draw,
  ifscg_plot_if.source                  plot,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ifscg_pkg::PADDR_W-1:0] paddr,
  input  logic [ifscg_pkg::PDATA_W-1:0] pwdata,
  output logic [ifscg_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);

  ifscg_pkg::cfg_t  cfg;
  ifscg_pkg::cw_t   cw;
  ifscg_pkg::stat_t stat;
  logic             out_free;

  // draw accepted only in the idle step of the program
  assign draw.ready    = cw.in_ready;
  assign stat.in_fire  = draw.valid && cw.in_ready;
  assign stat.out_free = out_free;

  ifscg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ifscg_ucode u_ucode (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cw   (cw)
  );

  ifscg_datapath #(
    .SCREEN_HALF_WIDTH  (SCREEN_HALF_WIDTH),
    .SCREEN_HALF_HEIGHT (SCREEN_HALF_HEIGHT),
    .FRACTION_BITS      (FRACTION_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cw           (cw),
    .cfg          (cfg),
    .in_fire      (stat.in_fire),
    .random_value (draw.random_value),
    .out_ready    (plot.ready),
    .out_free     (out_free),
    .out_valid    (plot.valid),
    .column       (plot.column),
    .row          (plot.row),
    .on_screen    (plot.on_screen),
    .map_index    (plot.map_index)
  );

endmodule
